// ----- rtl/live_pointer_set_alloc_classifier_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef LIVE_POINTER_SET_ALLOC_CLASSIFIER_TOP_DEFINES_SVH
`define LIVE_POINTER_SET_ALLOC_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LPSAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpsac check failed");

// Next-cycle implication, disabled while reset is held.
`define LPSAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpsac check failed");

`endif

// ----- rtl/lpsac_pkg.sv -----
`default_nettype none
package lpsac_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam logic [63:0] MIX_MULT = 64'hff51afd7ed558ccd;
    localparam int MIX_SHIFT = 33;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [2:0] CLS_ALLOC_REAL = 3'd0;
    localparam logic [2:0] CLS_ALLOC_SENT = 3'd1;
    localparam logic [2:0] CLS_FREE_REAL  = 3'd2;
    localparam logic [2:0] CLS_FREE_NOOP  = 3'd3;
    localparam logic [2:0] CLS_CLEARED    = 3'd4;
    localparam logic [2:0] CLS_FULL       = 3'd5;

    typedef enum logic [1:0] {IDX_HOLD, IDX_HASH, IDX_INC, IDX_ZERO} t_idx_op;
    typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_ONE, CNT_INC} t_cnt_op;
    typedef enum logic [1:0] {WD_ADDR, WD_ZERO, WD_RD} t_wd_sel;

    typedef struct packed {
        logic       in_ready;
        logic       hash_start;
        logic       hash_rd;
        t_idx_op    idx_op;
        t_cnt_op    cnt_op;
        logic       gap_set;
        logic       rd_en;
        logic       wr_en;
        logic       wr_gap;
        t_wd_sel    wd_sel;
        logic       fin;
        logic       emit;
        logic [2:0] cls;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] mode;
        logic       is_sent;
        logic       addr_zero;
        logic       addr_is_sent;
        logic       full;
        logic       hash_done;
        logic       rd_zero;
        logic       rd_match;
        logic       cnt_last;
        logic       cnt_full;
        logic       move;
        logic       idx_last;
        logic       out_free;
    } t_stat;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lpsac_in_if.sv -----
`default_nettype none
interface lpsac_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [63:0]        address;
    logic [31:0]        elem_size;
    logic signed [31:0] length;
    logic signed [31:0] capacity;

    modport source (output valid, mode, address, elem_size, length, capacity, input ready);
    modport sink (input valid, mode, address, elem_size, length, capacity, output ready);
endinterface
`default_nettype wire

// ----- rtl/lpsac_out_if.sv -----
`default_nettype none
interface lpsac_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_class;
    logic [31:0] live_entries;
    logic [31:0] alloc_count;
    logic [31:0] real_alloc_count;
    logic [31:0] sentinel_count;
    logic [31:0] free_count;
    logic [31:0] real_free_count;
    logic [31:0] noop_free_count;

    modport source (output valid, event_class, live_entries, alloc_count, real_alloc_count,
                    sentinel_count, free_count, real_free_count, noop_free_count,
                    input ready);
    modport sink (input valid, event_class, live_entries, alloc_count, real_alloc_count,
                  sentinel_count, free_count, real_free_count, noop_free_count,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/lpsac_hash.sv -----
`default_nettype none
// Mix hash computed step by step, one 32x32 product per cycle.
module lpsac_hash #(
    parameter int IDX_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [63:0]      i_key,
    output logic                  o_done,
    output logic [IDX_W-1:0]      o_idx
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_M0   = 6'b000010,
        ST_M1   = 6'b000100,
        ST_M2   = 6'b001000,
        ST_SUM  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_hash_step;

    t_hash_step       r_step;
    logic             r_done;
    logic [63:0]      r_y;
    logic [63:0]      r_p0;
    logic [31:0]      r_p1;
    logic [31:0]      r_p2;
    logic [63:0]      r_x;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;

    always_comb begin
        unique case (r_step)
            ST_M1: begin
                mul_a = r_y[31:0];
                mul_b = lpsac_pkg::MIX_MULT[63:32];
            end
            ST_M2: begin
                mul_a = r_y[63:32];
                mul_b = lpsac_pkg::MIX_MULT[31:0];
            end
            default: begin
                mul_a = r_y[31:0];
                mul_b = lpsac_pkg::MIX_MULT[31:0];
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                ST_IDLE: if (i_start) r_step <= ST_M0;
                ST_M0:   r_step <= ST_M1;
                ST_M1:   r_step <= ST_M2;
                ST_M2:   r_step <= ST_SUM;
                ST_SUM:  r_step <= ST_OUT;
                ST_OUT: begin
                    r_step <= ST_IDLE;
                    r_done <= 1'b1;
                end
                default: r_step <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == ST_IDLE && i_start) r_y <= i_key ^ (i_key >> lpsac_pkg::MIX_SHIFT);
        if (r_step == ST_M0) r_p0 <= prod;
        if (r_step == ST_M1) r_p1 <= prod[31:0];
        if (r_step == ST_M2) r_p2 <= prod[31:0];
        if (r_step == ST_SUM) r_x <= r_p0 + {r_p1 + r_p2, 32'h0};
        if (r_step == ST_OUT) r_idx <= r_x[IDX_W-1:0] ^ r_x[lpsac_pkg::MIX_SHIFT +: IDX_W];
    end

    assign o_done = r_done;
    assign o_idx  = r_idx;
endmodule
`default_nettype wire

// ----- rtl/lpsac_ctrl.sv -----
`default_nettype none
// Sequencer: probe, insert, backward-shift walk, clearing sweep, result hand-off.
module lpsac_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lpsac_pkg::t_stat i_stat,
    output lpsac_pkg::t_cmd       o_cmd
);
    typedef enum logic [12:0] {
        S_SWEEP   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_DECODE  = 13'b0000000000100,
        S_HASH    = 13'b0000000001000,
        S_RD      = 13'b0000000010000,
        S_CHK     = 13'b0000000100000,
        S_SH_RD   = 13'b0000001000000,
        S_SH_CHK  = 13'b0000010000000,
        S_SH_HASH = 13'b0000100000000,
        S_SH_MV   = 13'b0001000000000,
        S_SH_ZERO = 13'b0010000000000,
        S_FIN     = 13'b0100000000000,
        S_EMIT    = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cls, n_cls;
    logic       r_emit_pend, n_emit_pend;

    always_comb begin
        n_state     = r_state;
        n_cls       = r_cls;
        n_emit_pend = r_emit_pend;
        o_cmd            = '0;
        o_cmd.idx_op     = lpsac_pkg::IDX_HOLD;
        o_cmd.cnt_op     = lpsac_pkg::CNT_HOLD;
        o_cmd.wd_sel     = lpsac_pkg::WD_ZERO;
        o_cmd.cls        = r_cls;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = lpsac_pkg::IDX_INC;
                if (i_stat.idx_last) begin
                    n_state     = r_emit_pend ? S_EMIT : S_IDLE;
                    n_emit_pend = 1'b0;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (i_stat.mode == lpsac_pkg::MODE_ALLOC) begin
                    priority if (i_stat.is_sent) begin
                        n_cls = lpsac_pkg::CLS_ALLOC_SENT;  n_state = S_FIN;
                    end else if (i_stat.addr_zero) begin
                        n_cls = lpsac_pkg::CLS_ALLOC_REAL;  n_state = S_FIN;
                    end else if (i_stat.full) begin
                        n_cls = lpsac_pkg::CLS_FULL;        n_state = S_FIN;
                    end else begin
                        o_cmd.hash_start = 1'b1;            n_state = S_HASH;
                    end
                end else if (i_stat.mode == lpsac_pkg::MODE_FREE) begin
                    if (i_stat.addr_zero || i_stat.addr_is_sent) begin
                        n_cls = lpsac_pkg::CLS_FREE_NOOP;   n_state = S_FIN;
                    end else begin
                        o_cmd.hash_start = 1'b1;            n_state = S_HASH;
                    end
                end else if (i_stat.mode == lpsac_pkg::MODE_CLEAR) begin
                    n_cls = lpsac_pkg::CLS_CLEARED;         n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.idx_op = lpsac_pkg::IDX_HASH;
                    o_cmd.cnt_op = lpsac_pkg::CNT_ZERO;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (i_stat.mode == lpsac_pkg::MODE_ALLOC) begin
                    if (i_stat.rd_zero) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wd_sel = lpsac_pkg::WD_ADDR;
                        n_cls        = lpsac_pkg::CLS_ALLOC_REAL;
                        n_state      = S_FIN;
                    end else begin
                        o_cmd.idx_op = lpsac_pkg::IDX_INC;
                        n_state      = S_RD;
                    end
                end else begin
                    priority if (i_stat.rd_zero) begin
                        n_cls   = lpsac_pkg::CLS_FREE_NOOP;
                        n_state = S_FIN;
                    end else if (i_stat.rd_match) begin
                        // drop the entry, then start the backward-shift walk
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.gap_set = 1'b1;
                        o_cmd.idx_op  = lpsac_pkg::IDX_INC;
                        o_cmd.cnt_op  = lpsac_pkg::CNT_ONE;
                        n_state       = S_SH_RD;
                    end else if (i_stat.cnt_last) begin
                        n_cls   = lpsac_pkg::CLS_FREE_NOOP;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.idx_op = lpsac_pkg::IDX_INC;
                        o_cmd.cnt_op = lpsac_pkg::CNT_INC;
                        n_state      = S_RD;
                    end
                end
            end
            S_SH_RD: begin
                if (i_stat.cnt_full) begin
                    n_cls   = lpsac_pkg::CLS_FREE_REAL;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SH_CHK;
                end
            end
            S_SH_CHK: begin
                if (i_stat.rd_zero) begin
                    n_cls   = lpsac_pkg::CLS_FREE_REAL;
                    n_state = S_FIN;
                end else begin
                    o_cmd.hash_start = 1'b1;
                    o_cmd.hash_rd    = 1'b1;
                    n_state          = S_SH_HASH;
                end
            end
            S_SH_HASH: begin
                if (i_stat.hash_done) begin
                    if (i_stat.move) begin
                        n_state = S_SH_MV;
                    end else begin
                        o_cmd.idx_op = lpsac_pkg::IDX_INC;
                        o_cmd.cnt_op = lpsac_pkg::CNT_INC;
                        n_state      = S_SH_RD;
                    end
                end
            end
            S_SH_MV: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_gap = 1'b1;
                o_cmd.wd_sel = lpsac_pkg::WD_RD;
                n_state      = S_SH_ZERO;
            end
            S_SH_ZERO: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.gap_set = 1'b1;
                o_cmd.idx_op  = lpsac_pkg::IDX_INC;
                o_cmd.cnt_op  = lpsac_pkg::CNT_INC;
                n_state       = S_SH_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (r_cls == lpsac_pkg::CLS_CLEARED) begin
                    o_cmd.idx_op = lpsac_pkg::IDX_ZERO;
                    n_emit_pend  = 1'b1;
                    n_state      = S_SWEEP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cls       <= lpsac_pkg::CLS_ALLOC_REAL;
            r_emit_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cls       <= n_cls;
            r_emit_pend <= n_emit_pend;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lpsac_dp.sv -----
`default_nettype none
// Slot memory, probe pointers, counters and the result register.
module lpsac_dp #(
    parameter int TABLE_DEPTH = lpsac_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    lpsac_in_if.sink             i_item,
    lpsac_out_if.source          o_res,
    input  wire lpsac_pkg::t_cmd i_cmd,
    output lpsac_pkg::t_stat     o_stat
);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    logic [63:0]        mem [TABLE_DEPTH];

    logic [1:0]         r_mode;
    logic [63:0]        r_addr;
    logic [31:0]        r_es;
    logic signed [31:0] r_len;
    logic signed [31:0] r_cap;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_gap;
    logic [CNT_W-1:0]   r_cnt;
    logic [63:0]        r_rd;
    logic [63:0]        r_sent;
    logic [31:0]        r_live;
    logic [31:0]        r_a_calls, r_a_real, r_a_sent, r_f_calls, r_f_real, r_f_noop;
    logic               r_out_valid;

    logic               hash_done;
    logic [IDX_W-1:0]   hash_idx;
    logic signed [31:0] eff;
    logic [IDX_W-1:0]   wr_a;
    logic [63:0]        wr_d;

    lpsac_hash #(.IDX_W(IDX_W)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_key   (i_cmd.hash_rd ? r_rd : r_addr),
        .o_done  (hash_done),
        .o_idx   (hash_idx)
    );

    assign i_item.ready = i_cmd.in_ready;
    assign eff = (r_cap < r_len) ? r_len : r_cap;

    always_comb begin
        o_stat.in_valid     = i_item.valid;
        o_stat.mode         = r_mode;
        o_stat.is_sent      = (r_es == 32'd0) || (eff == 32'sd0);
        o_stat.addr_zero    = (r_addr == 64'd0);
        o_stat.addr_is_sent = (r_addr == r_sent);
        o_stat.full         = (r_live >= 32'(TABLE_DEPTH));
        o_stat.hash_done    = hash_done;
        o_stat.rd_zero      = (r_rd == 64'd0);
        o_stat.rd_match     = (r_rd == r_addr);
        o_stat.cnt_last     = (r_cnt == CNT_W'(TABLE_DEPTH - 1));
        o_stat.cnt_full     = (r_cnt == CNT_W'(TABLE_DEPTH));
        // shift the entry back when its home lies cyclically outside (gap, k]
        o_stat.move         = (r_idx > r_gap)
                            ? (hash_idx <= r_gap || hash_idx > r_idx)
                            : (hash_idx <= r_gap && hash_idx > r_idx);
        o_stat.idx_last     = (r_idx == IDX_W'(TABLE_DEPTH - 1));
        o_stat.out_free     = !r_out_valid || o_res.ready;
    end

    always_comb begin
        wr_a = i_cmd.wr_gap ? r_gap : r_idx;
        unique case (i_cmd.wd_sel)
            lpsac_pkg::WD_ADDR: wr_d = r_addr;
            lpsac_pkg::WD_RD:   wr_d = r_rd;
            default:            wr_d = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) mem[wr_a] <= wr_d;
        if (i_cmd.rd_en) r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready && i_item.valid) begin
            r_mode <= i_item.mode;
            r_addr <= i_item.address;
            r_es   <= i_item.elem_size;
            r_len  <= i_item.length;
            r_cap  <= i_item.capacity;
        end
        if (i_cmd.gap_set) r_gap <= r_idx;
        unique case (i_cmd.cnt_op)
            lpsac_pkg::CNT_ZERO: r_cnt <= '0;
            lpsac_pkg::CNT_ONE:  r_cnt <= CNT_W'(1);
            lpsac_pkg::CNT_INC:  r_cnt <= r_cnt + CNT_W'(1);
            default:             r_cnt <= r_cnt;
        endcase
        if (i_cmd.emit) begin
            o_res.event_class      <= i_cmd.cls;
            o_res.live_entries     <= r_live;
            o_res.alloc_count      <= r_a_calls;
            o_res.real_alloc_count <= r_a_real;
            o_res.sentinel_count   <= r_a_sent;
            o_res.free_count       <= r_f_calls;
            o_res.real_free_count  <= r_f_real;
            o_res.noop_free_count  <= r_f_noop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sent      <= 64'd0;
            r_live      <= 32'd0;
            r_a_calls   <= 32'd0;
            r_a_real    <= 32'd0;
            r_a_sent    <= 32'd0;
            r_f_calls   <= 32'd0;
            r_f_real    <= 32'd0;
            r_f_noop    <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.idx_op)
                lpsac_pkg::IDX_HASH: r_idx <= hash_idx;
                lpsac_pkg::IDX_INC:  r_idx <= r_idx + IDX_W'(1);
                lpsac_pkg::IDX_ZERO: r_idx <= '0;
                default:             r_idx <= r_idx;
            endcase
            if (i_cmd.fin) begin
                unique case (i_cmd.cls)
                    lpsac_pkg::CLS_ALLOC_REAL: begin
                        r_a_calls <= lpsac_pkg::sat_inc(r_a_calls);
                        r_a_real  <= lpsac_pkg::sat_inc(r_a_real);
                        if (r_addr != 64'd0) r_live <= r_live + 32'd1;
                    end
                    lpsac_pkg::CLS_ALLOC_SENT: begin
                        r_a_calls <= lpsac_pkg::sat_inc(r_a_calls);
                        r_a_sent  <= lpsac_pkg::sat_inc(r_a_sent);
                        if (r_sent == 64'd0) r_sent <= r_addr;
                    end
                    lpsac_pkg::CLS_FREE_REAL: begin
                        r_f_calls <= lpsac_pkg::sat_inc(r_f_calls);
                        r_f_real  <= lpsac_pkg::sat_inc(r_f_real);
                        if (r_live != 32'd0) r_live <= r_live - 32'd1;
                    end
                    lpsac_pkg::CLS_FREE_NOOP: begin
                        r_f_calls <= lpsac_pkg::sat_inc(r_f_calls);
                        r_f_noop  <= lpsac_pkg::sat_inc(r_f_noop);
                    end
                    lpsac_pkg::CLS_CLEARED: begin
                        r_live    <= 32'd0;
                        r_a_calls <= 32'd0;
                        r_a_real  <= 32'd0;
                        r_a_sent  <= 32'd0;
                        r_f_calls <= 32'd0;
                        r_f_real  <= 32'd0;
                        r_f_noop  <= 32'd0;
                    end
                    lpsac_pkg::CLS_FULL: r_a_calls <= lpsac_pkg::sat_inc(r_a_calls);
                    default: r_live <= r_live;
                endcase
            end
            if (i_cmd.emit)       r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid = r_out_valid;
endmodule
`default_nettype wire

// ----- rtl/live_pointer_set_alloc_classifier_top.sv -----
`default_nettype none
// Channel   Modport  Direction  Payload
// i_item    sink     in         mode, address, elem_size, length, capacity
// o_res     source   out        event_class, live_entries, six call counters
//
// Steps: sentinel, null, full and no-op-by-address items go from decode to the result,
//   undefined items to idle; an insert hashes on the shared hash unit, then checks each
//   probed slot; a free probes alike, then walks to an empty slot, moving entries back.
// Reset: a sweep zeroes the slot memory; no item is taken.
// Clear: the result follows a sweep that zeroes the slot memory.
// Stalls: an item is taken while an earlier result waits; TABLE_DEPTH must be a power of two (not checked here).
module live_pointer_set_alloc_classifier_top #(
    parameter int TABLE_DEPTH = lpsac_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lpsac_in_if.sink    i_item,
    lpsac_out_if.source o_res
);
    // command and status between sequencer and datapath
    lpsac_pkg::t_cmd  cmd;
    lpsac_pkg::t_stat stat;

    lpsac_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // slot memory, hash unit and counters
    lpsac_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule
`default_nettype wire

// ----- rtl/lpsac_checker.sv -----
`default_nettype none
`include "live_pointer_set_alloc_classifier_top_defines.svh"
module lpsac_checker #(
    parameter int TABLE_DEPTH = lpsac_pkg::TABLE_DEPTH_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_event_class,
    input wire logic [31:0] i_live_entries,
    input wire logic [31:0] i_alloc_count,
    input wire logic [31:0] i_real_alloc_count
);
    logic        out_stall;
    logic [34:0] res_key;
    logic        in_take;
    logic        live_ok;
    logic        clr_res;
    logic        clr_zero;

    assign out_stall = i_out_valid && !i_out_ready;
    assign res_key   = {i_event_class, i_live_entries};
    assign in_take   = i_in_valid && i_in_ready;
    assign live_ok   = i_live_entries <= 32'(TABLE_DEPTH);
    assign clr_res   = i_out_valid && i_event_class == lpsac_pkg::CLS_CLEARED;
    assign clr_zero  = i_live_entries == 32'd0 && i_alloc_count == 32'd0
                       && i_real_alloc_count == 32'd0;

    `LPSAC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(res_key))
    `LPSAC_ASSERT_NXT(a_in_busy, i_clk, i_rst_n, in_take, !i_in_ready)
    `LPSAC_ASSERT_IMP(a_live_bound, i_clk, i_rst_n, i_out_valid, live_ok)
    `LPSAC_ASSERT_IMP(a_clear_zero, i_clk, i_rst_n, clr_res, clr_zero)
endmodule

bind live_pointer_set_alloc_classifier_top lpsac_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_item.valid),
    .i_in_ready         (i_item.ready),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_event_class      (o_res.event_class),
    .i_live_entries     (o_res.live_entries),
    .i_alloc_count      (o_res.alloc_count),
    .i_real_alloc_count (o_res.real_alloc_count)
);
`default_nettype wire

// ----- tb/live_pointer_set_alloc_classifier_top_test.sv -----
`default_nettype none
module live_pointer_set_alloc_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = lpsac_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RAND_ITEMS  = 700;

    // One stimulus item; hold_for_drain keeps it back until no result is due.
    typedef struct {
        logic [1:0]         mode;
        logic [63:0]        address;
        logic [31:0]        elem_size;
        logic signed [31:0] length;
        logic signed [31:0] capacity;
        bit                 hold_for_drain;
    } t_event;

    typedef struct {
        logic [2:0]  cls;
        logic [31:0] live;
        logic [31:0] cnt [6];
    } t_summary;

    logic i_clk;
    logic i_rst_n;

    lpsac_in_if  item_if ();
    lpsac_out_if res_if ();

    live_pointer_set_alloc_classifier_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .o_res   (res_if.source)
    );

    t_event   event_queue [$];
    t_summary summary_due [$];
    logic [63:0] issued_addrs [$];

    // Shadow of the block's state.
    logic [63:0] shadow_slots [DEPTH];
    logic [63:0] shadow_sentinel;
    logic [31:0] shadow_live;
    logic [31:0] shadow_cnt [6]; // alloc calls/real/sentinel, free calls/real/noop
    logic [63:0] shadow_sentinel_guess;

    int  mismatches;
    int  cls_seen [6];
    int  cycle_count;
    bit  item_taken;
    int  burst_left;
    int  gap_left;
    int  stall_phase;
    int  stall_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int home_slot(input logic [63:0] a);
        logic [63:0] h;
        h = a ^ (a >> lpsac_pkg::MIX_SHIFT);
        h = h * lpsac_pkg::MIX_MULT;
        h = h ^ (h >> lpsac_pkg::MIX_SHIFT);
        return int'(h % DEPTH);
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic bit shadow_insert(input logic [63:0] a);
        int i;
        if (shadow_live >= DEPTH) return 1'b0;
        i = home_slot(a);
        for (int n = 0; n < DEPTH; n++) begin
            if (shadow_slots[i] == 64'd0) begin
                shadow_slots[i] = a;
                shadow_live++;
                return 1'b1;
            end
            i = (i + 1) % DEPTH;
        end
        return 1'b0;
    endfunction

    // Find and remove, then close the hole by shifting later chain members back.
    function automatic bit shadow_remove(input logic [63:0] a);
        int i, gap, k, h;
        bit shift;
        i = home_slot(a);
        for (int n = 0; n < DEPTH && shadow_slots[i] != 64'd0; n++) begin
            if (shadow_slots[i] == a) begin
                gap = i;
                k = (i + 1) % DEPTH;
                shadow_slots[i] = 64'd0;
                for (int m = 1; m < DEPTH && shadow_slots[k] != 64'd0; m++) begin
                    h = home_slot(shadow_slots[k]);
                    shift = (k > gap) ? (h <= gap || h > k) : (h <= gap && h > k);
                    if (shift) begin
                        shadow_slots[gap] = shadow_slots[k];
                        shadow_slots[k] = 64'd0;
                        gap = k;
                    end
                    k = (k + 1) % DEPTH;
                end
                if (shadow_live > 0) shadow_live--;
                return 1'b1;
            end
            i = (i + 1) % DEPTH;
        end
        return 1'b0;
    endfunction

    function automatic void shadow_clear();
        foreach (shadow_slots[j]) shadow_slots[j] = 64'd0;
        shadow_live = 32'd0;
        foreach (shadow_cnt[j]) shadow_cnt[j] = 32'd0;
    endfunction

    // Work out the summary an accepted item yields; undefined mode yields none.
    function automatic void classify_event(input t_event ev);
        t_summary s;
        logic signed [31:0] eff;
        if (ev.mode == lpsac_pkg::MODE_ALLOC) begin
            eff = (ev.capacity < ev.length) ? ev.length : ev.capacity;
            shadow_cnt[0] = bump(shadow_cnt[0]);
            if (ev.elem_size == 32'd0 || eff == 32'sd0) begin
                shadow_cnt[2] = bump(shadow_cnt[2]);
                if (shadow_sentinel == 64'd0) shadow_sentinel = ev.address;
                s.cls = lpsac_pkg::CLS_ALLOC_SENT;
            end else if (ev.address == 64'd0 || shadow_insert(ev.address)) begin
                shadow_cnt[1] = bump(shadow_cnt[1]);
                s.cls = lpsac_pkg::CLS_ALLOC_REAL;
            end else begin
                s.cls = lpsac_pkg::CLS_FULL;
            end
        end else if (ev.mode == lpsac_pkg::MODE_FREE) begin
            shadow_cnt[3] = bump(shadow_cnt[3]);
            if (ev.address != 64'd0 && ev.address != shadow_sentinel
                    && shadow_remove(ev.address)) begin
                shadow_cnt[4] = bump(shadow_cnt[4]);
                s.cls = lpsac_pkg::CLS_FREE_REAL;
            end else begin
                shadow_cnt[5] = bump(shadow_cnt[5]);
                s.cls = lpsac_pkg::CLS_FREE_NOOP;
            end
        end else if (ev.mode == lpsac_pkg::MODE_CLEAR) begin
            shadow_clear();
            s.cls = lpsac_pkg::CLS_CLEARED;
        end else begin
            return;
        end
        s.live = shadow_live;
        s.cnt = shadow_cnt;
        summary_due.push_back(s);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic queue_event(input logic [1:0] mode, input logic [63:0] addr,
                               input logic [31:0] es, input logic signed [31:0] len,
                               input logic signed [31:0] cap, input bit drain = 1'b0);
        t_event ev;
        ev.mode = mode;
        ev.address = addr;
        ev.elem_size = es;
        ev.length = len;
        ev.capacity = cap;
        ev.hold_for_drain = drain;
        event_queue.push_back(ev);
    endtask

    function automatic logic [63:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [31:0] rand_size();
        return $urandom_range(1, 4096);
    endfunction

    // Mostly well-formed alloc/free traffic over live addresses, with noise mixed in.
    task automatic queue_random(input int count);
        int pick, idx;
        logic [63:0] a;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || (issued_addrs.size() == 0 && pick < 70)) begin
                a = ($urandom_range(0, 9) == 0 && issued_addrs.size() > 0)
                    ? issued_addrs[$urandom_range(0, issued_addrs.size() - 1)]
                    : rand_addr();
                queue_event(lpsac_pkg::MODE_ALLOC, a,
                            $urandom_range(1, 64) << $urandom_range(0, 20),
                            ($urandom_range(0, 3) == 0) ? $signed($urandom) : rand_size(),
                            $signed($urandom));
                issued_addrs.push_back(a);
            end else if (pick < 75) begin
                if (issued_addrs.size() > 0) begin
                    idx = $urandom_range(0, issued_addrs.size() - 1);
                    queue_event(lpsac_pkg::MODE_FREE, issued_addrs[idx],
                                $urandom, $urandom, $urandom);
                    issued_addrs.delete(idx);
                end else begin
                    queue_event(lpsac_pkg::MODE_FREE, rand_addr(), $urandom, $urandom,
                                $urandom);
                end
            end else if (pick < 82) begin
                // sentinel: zero element size, or the larger of length and capacity equal to zero
                case ($urandom_range(0, 2))
                    0: queue_event(lpsac_pkg::MODE_ALLOC, rand_addr(), 32'd0, rand_size(),
                                   rand_size());
                    1: queue_event(lpsac_pkg::MODE_ALLOC, rand_addr(), $urandom, 32'sd0,
                                   -$signed($urandom_range(0, 1000)));
                    default: queue_event(lpsac_pkg::MODE_ALLOC, rand_addr(), $urandom,
                                         -$signed($urandom_range(0, 1000)), 32'sd0);
                endcase
            end else if (pick < 86) begin
                queue_event(lpsac_pkg::MODE_ALLOC, 64'd0, $urandom_range(1, 100),
                            rand_size(), 32'sd5);
            end else if (pick < 91) begin
                queue_event(lpsac_pkg::MODE_FREE,
                            ($urandom_range(0, 1) == 0) ? 64'd0 : rand_addr(),
                            $urandom, $urandom, $urandom);
            end else if (pick < 93) begin
                queue_event(lpsac_pkg::MODE_FREE, shadow_sentinel_guess, $urandom,
                            $urandom, $urandom);
            end else if (pick < 95) begin
                queue_event(lpsac_pkg::MODE_RSVD, rand_addr(), $urandom, $urandom,
                            $urandom);
                n--; // ignored by the block, does not count
            end else if (pick == 95 && $urandom_range(0, 3) == 0) begin
                queue_event(lpsac_pkg::MODE_CLEAR, rand_addr(), $urandom, $urandom,
                            $urandom);
                issued_addrs.delete();
            end else begin
                queue_event(lpsac_pkg::MODE_ALLOC, rand_addr(), 32'hFFFF_FFFF,
                            32'sh7FFF_FFFF, 32'sh8000_0000);
            end
            // keep the load moderate so probe chains stay short
            if (issued_addrs.size() > 400) begin
                queue_event(lpsac_pkg::MODE_FREE, issued_addrs[0], $urandom, $urandom,
                            $urandom);
                issued_addrs.delete(0);
            end
        end
    endtask

    // Stimulus: directed corners, a full-table episode, then random traffic.
    initial begin
        logic [63:0] s_addr;
        s_addr = 64'hDEAD_0000_BEEF_0001;
        shadow_sentinel_guess = s_addr;

        queue_event(lpsac_pkg::MODE_FREE, 64'd0, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_ALLOC, 64'd0, 32'd0, 32'sd1, 32'sd1);    // null sentinel
        queue_event(lpsac_pkg::MODE_ALLOC, s_addr, 32'd8, 32'sd0, -32'sd3);  // recorded
        queue_event(lpsac_pkg::MODE_ALLOC, 64'h1234, 32'd0, 32'sd9, 32'sd9); // kept out
        queue_event(lpsac_pkg::MODE_ALLOC, s_addr, 32'd4, 32'sd1, 32'sd0);   // real
        queue_event(lpsac_pkg::MODE_FREE, s_addr, 32'd0, 32'sd0, 32'sd0);    // noop
        queue_event(lpsac_pkg::MODE_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_event(lpsac_pkg::MODE_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'sh8000_0000,
                    32'sh7FFF_FFFF);                                // duplicate
        queue_event(lpsac_pkg::MODE_ALLOC, 64'h0000_0000_0000_0001, 32'd1, -32'sd1,
                    -32'sd1);
        queue_event(lpsac_pkg::MODE_ALLOC, 64'd0, 32'd16, 32'sd4, 32'sd4);   // null real
        queue_event(lpsac_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_FREE, 64'h0000_0000_0000_0001, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_FREE, 64'h5555_AAAA_5555_AAAA, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_RSVD, 64'hAAAA_5555_AAAA_5555, 32'hFFFF_FFFF,
                    -32'sd1, -32'sd1);
        queue_event(lpsac_pkg::MODE_CLEAR, 64'd0, 32'd0, 32'sd0, 32'sd0, 1'b1);
        queue_event(lpsac_pkg::MODE_FREE, s_addr, 32'd0, 32'sd0, 32'sd0); // survives clear

        // Fill every slot, overflow, then null, sentinel and no-op free items, then clear.
        for (int n = 0; n < DEPTH; n++)
            queue_event(lpsac_pkg::MODE_ALLOC, rand_addr() | 64'd1, $urandom_range(1, 32),
                        rand_size(), 32'sd0);
        queue_event(lpsac_pkg::MODE_ALLOC, rand_addr() | 64'd1, 32'd4, 32'sd4, 32'sd4);
        queue_event(lpsac_pkg::MODE_ALLOC, 64'd0, 32'd4, 32'sd4, 32'sd4);   // null real
        queue_event(lpsac_pkg::MODE_ALLOC, 64'h77, 32'd0, 32'sd4, 32'sd4);  // sentinel
        queue_event(lpsac_pkg::MODE_FREE, 64'hFACE_FACE_FACE_FACE, 32'd0, 32'sd0, 32'sd0);
        queue_event(lpsac_pkg::MODE_CLEAR, 64'd0, 32'd0, 32'sd0, 32'sd0, 1'b1);

        queue_random(RAND_ITEMS / 2);
        // pause the sender until everything outstanding has come back
        queue_event(lpsac_pkg::MODE_FREE, rand_addr(), $urandom, $urandom, $urandom, 1'b1);
        queue_random(RAND_ITEMS / 2);
    end

    // Driver: present queued items in bursts with random gaps.
    always @(negedge i_clk) begin
        t_event ev;
        bit present;
        present = 1'b0;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || item_taken) begin
            item_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (event_queue.size() > 0 &&
                         !(event_queue[0].hold_for_drain && summary_due.size() > 0)) begin
                ev = event_queue.pop_front();
                present = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            item_if.valid <= present;
            if (present) begin
                item_if.mode      <= ev.mode;
                item_if.address   <= ev.address;
                item_if.elem_size <= ev.elem_size;
                item_if.length    <= ev.length;
                item_if.capacity  <= ev.capacity;
            end
        end
    end

    // Receiver stalls: stretches of none, of random stalls, and of long holds.
    always @(negedge i_clk) begin
        if (stall_len == 0) begin
            stall_phase = $urandom_range(0, 2);
            stall_len = $urandom_range(20, 300);
        end
        stall_len--;
        case (stall_phase)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 1) == 1);
            default: res_if.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Monitor: check results first, then predict for the item taken at this edge.
    always @(posedge i_clk) begin
        t_summary want;
        t_event ev;
        cycle_count++;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (summary_due.size() == 0) begin
                report_mismatch("unexpected result, class", res_if.event_class, 0);
            end else begin
                want = summary_due.pop_front();
                if (res_if.event_class != want.cls)
                    report_mismatch("event_class", res_if.event_class, want.cls);
                else if (want.cls <= lpsac_pkg::CLS_FULL)
                    cls_seen[want.cls]++;
                if (res_if.live_entries != want.live)
                    report_mismatch("live_entries", res_if.live_entries, want.live);
                if (res_if.alloc_count != want.cnt[0])
                    report_mismatch("alloc_count", res_if.alloc_count, want.cnt[0]);
                if (res_if.real_alloc_count != want.cnt[1])
                    report_mismatch("real_alloc_count", res_if.real_alloc_count,
                                    want.cnt[1]);
                if (res_if.sentinel_count != want.cnt[2])
                    report_mismatch("sentinel_count", res_if.sentinel_count, want.cnt[2]);
                if (res_if.free_count != want.cnt[3])
                    report_mismatch("free_count", res_if.free_count, want.cnt[3]);
                if (res_if.real_free_count != want.cnt[4])
                    report_mismatch("real_free_count", res_if.real_free_count,
                                    want.cnt[4]);
                if (res_if.noop_free_count != want.cnt[5])
                    report_mismatch("noop_free_count", res_if.noop_free_count,
                                    want.cnt[5]);
            end
        end
        if (i_rst_n && item_if.valid && item_if.ready) begin
            item_taken = 1'b1;
            ev.mode = item_if.mode;
            ev.address = item_if.address;
            ev.elem_size = item_if.elem_size;
            ev.length = item_if.length;
            ev.capacity = item_if.capacity;
            classify_event(ev);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", summary_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Reset, then wait for the stimulus to drain and close the run.
    initial begin
        item_if.valid = 1'b0;
        item_if.mode = lpsac_pkg::MODE_ALLOC;
        item_if.address = 64'd0;
        item_if.elem_size = 32'd0;
        item_if.length = 32'sd0;
        item_if.capacity = 32'sd0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        shadow_clear();
        shadow_sentinel = 64'd0;
        mismatches = 0;
        cycle_count = 0;
        item_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_len = 0;
        foreach (cls_seen[j]) cls_seen[j] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        wait (event_queue.size() == 0 && !item_if.valid);
        wait (summary_due.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("Covered: %0d real allocs, %0d sentinel allocs, %0d real frees,",
                 cls_seen[lpsac_pkg::CLS_ALLOC_REAL], cls_seen[lpsac_pkg::CLS_ALLOC_SENT],
                 cls_seen[lpsac_pkg::CLS_FREE_REAL]);
        $display("  %0d no-op frees, %0d clears, %0d full-table drops; %0d mismatches in %0d cycles",
                 cls_seen[lpsac_pkg::CLS_FREE_NOOP], cls_seen[lpsac_pkg::CLS_CLEARED],
                 cls_seen[lpsac_pkg::CLS_FULL], mismatches, cycle_count);
        if (mismatches == 0 && summary_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ----- live_pointer_set_alloc_classifier_top.f -----
+incdir+rtl
rtl/lpsac_pkg.sv
rtl/lpsac_in_if.sv
rtl/lpsac_out_if.sv
rtl/lpsac_hash.sv
rtl/lpsac_ctrl.sv
rtl/lpsac_dp.sv
rtl/live_pointer_set_alloc_classifier_top.sv
rtl/lpsac_checker.sv
tb/live_pointer_set_alloc_classifier_top_test.sv
